>>> design/epr_pkg.sv
// Shared constants, types and the arctangent table for the Euler point rotation block.
`default_nettype none
package epr_pkg;

	localparam int COORD_WIDTH  = 32;
	localparam int ANGLE_WIDTH  = 16;
	// Internal coordinate width: the rotated vector never exceeds sqrt(3) times the input range.
	localparam int RW           = COORD_WIDTH + 2;
	localparam int TW           = 32;
	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam logic signed [TW-1:0] CORDIC_GAIN = TW'(652032874);
	// Split of a coordinate magnitude into two partial products.
	localparam int LO           = (RW + 1) / 2;
	localparam int HI           = RW - LO;

	typedef struct packed {
		logic signed [TW-1:0] x;
		logic signed [TW-1:0] y;
		logic signed [TW-1:0] z;
		logic [1:0]           quad;
	} epr_cordic_t;

	typedef struct packed {
		logic signed [RW-1:0] w;
		logic signed [TW-1:0] c0;
		logic signed [TW-1:0] s0;
		logic signed [TW-1:0] c1;
		logic signed [TW-1:0] s1;
	} epr_side_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic signed [TW-1:0] atan_turn(input logic [STEP_W-1:0] i);
		logic signed [TW-1:0] r;
		case (i)
			5'd0:  r = 32'sd536870912;
			5'd1:  r = 32'sd316933406;
			5'd2:  r = 32'sd167458907;
			5'd3:  r = 32'sd85004756;
			5'd4:  r = 32'sd42667331;
			5'd5:  r = 32'sd21354465;
			5'd6:  r = 32'sd10679838;
			5'd7:  r = 32'sd5340245;
			5'd8:  r = 32'sd2670163;
			5'd9:  r = 32'sd1335087;
			5'd10: r = 32'sd667544;
			5'd11: r = 32'sd333772;
			5'd12: r = 32'sd166886;
			5'd13: r = 32'sd83443;
			5'd14: r = 32'sd41722;
			5'd15: r = 32'sd20861;
			5'd16: r = 32'sd10430;
			5'd17: r = 32'sd5215;
			5'd18: r = 32'sd2608;
			5'd19: r = 32'sd1304;
			5'd20: r = 32'sd652;
			5'd21: r = 32'sd326;
			5'd22: r = 32'sd163;
			5'd23: r = 32'sd81;
			5'd24: r = 32'sd41;
			5'd25: r = 32'sd20;
			5'd26: r = 32'sd10;
			5'd27: r = 32'sd5;
			5'd28: r = 32'sd3;
			5'd29: r = 32'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/epr_cordic_cell.sv
// One rotation-mode CORDIC step with its output register.
`default_nettype none
module epr_cordic_cell (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic [epr_pkg::STEP_W-1:0]       step,
	input  wire epr_pkg::epr_cordic_t             d,
	output epr_pkg::epr_cordic_t                  q
);

	epr_pkg::epr_cordic_t nxt;
	logic signed [epr_pkg::TW-1:0] dx, dy, at;

	always_comb begin
		dx  = d.y >>> step;
		dy  = d.x >>> step;
		at  = epr_pkg::atan_turn(step);
		nxt = d;
		if (!d.z[epr_pkg::TW-1]) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - at;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> design/epr_rot.sv
// Four-stage plane rotation: p = u*c + v*s, q = v*c - u*s, with a side lane carried along.
`default_nettype none
module epr_rot (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [epr_pkg::RW-1:0]     u,
	input  wire logic signed [epr_pkg::RW-1:0]     v,
	input  wire logic signed [epr_pkg::TW-1:0]     c,
	input  wire logic signed [epr_pkg::TW-1:0]     s,
	input  wire epr_pkg::epr_side_t                side_i,
	output logic signed [epr_pkg::RW-1:0]          p,
	output logic signed [epr_pkg::RW-1:0]          q,
	output epr_pkg::epr_side_t                     side_o
);

	localparam int RW = epr_pkg::RW;
	localparam int TW = epr_pkg::TW;
	localparam int LO = epr_pkg::LO;
	localparam int HI = epr_pkg::HI;

	logic [RW-1:0] um_s1, vm_s1;
	logic [TW-1:0] cm_s1, sm_s1;
	logic          un_s1, vn_s1, cn_s1, sn_s1;
	epr_pkg::epr_side_t side_s1, side_s2, side_s3, side_s4;

	logic [LO+TW-1:0] pl_s2 [4];
	logic [HI+TW-1:0] ph_s2 [4];
	logic             ng_s2 [4];
	logic [RW-1:0]    am [4];
	logic [TW-1:0]    bm [4];
	logic             ng [4];

	logic signed [RW+1:0] r_s3 [4];
	logic [RW+32:0]       rs [4];
	logic [RW:0]          mag [4];

	logic signed [RW-1:0] p_s4, q_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			um_s1   <= u[RW-1] ? RW'(-u) : RW'(u);
			vm_s1   <= v[RW-1] ? RW'(-v) : RW'(v);
			cm_s1   <= c[TW-1] ? TW'(-c) : TW'(c);
			sm_s1   <= s[TW-1] ? TW'(-s) : TW'(s);
			un_s1   <= u[RW-1];
			vn_s1   <= v[RW-1];
			cn_s1   <= c[TW-1];
			sn_s1   <= s[TW-1];
			side_s1 <= side_i;
		end
	end

	// Products in order: u*c, v*s, v*c, u*s.
	always_comb begin
		am[0] = um_s1; bm[0] = cm_s1; ng[0] = un_s1 ^ cn_s1;
		am[1] = vm_s1; bm[1] = sm_s1; ng[1] = vn_s1 ^ sn_s1;
		am[2] = vm_s1; bm[2] = cm_s1; ng[2] = vn_s1 ^ cn_s1;
		am[3] = um_s1; bm[3] = sm_s1; ng[3] = un_s1 ^ sn_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				pl_s2[k] <= (LO+TW)'(am[k][LO-1:0]) * (LO+TW)'(bm[k]);
				ph_s2[k] <= (HI+TW)'(am[k][RW-1:LO]) * (HI+TW)'(bm[k]);
				ng_s2[k] <= ng[k];
			end
			side_s2 <= side_s1;
		end
	end

	// Round to nearest with ties away from zero, then apply the sign.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rs[k]  = ((RW+33)'(ph_s2[k]) << LO) + (RW+33)'(pl_s2[k]) + (RW+33)'(1 << 29);
			mag[k] = rs[k][RW+30:30];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				r_s3[k] <= ng_s2[k] ? -$signed({1'b0, mag[k]}) : $signed({1'b0, mag[k]});
			end
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s4    <= RW'(r_s3[0] + r_s3[1]);
			q_s4    <= RW'(r_s3[2] - r_s3[3]);
			side_s4 <= side_s3;
		end
	end

	assign p      = p_s4;
	assign q      = q_s4;
	assign side_o = side_s4;

endmodule
`default_nettype wire

>>> design/euler_point_rotation_xyz_core.sv
// Top level of the Euler point rotation block: CORDIC cell chains and three rotation stages.
`default_nettype none
// Usage
// Input channel: in_valid / in_stall with point_x, point_y, point_z (signed Q16.16) and
// angle_about_x/y/z (unsigned turn fractions). An item is taken at a rising edge where
// in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with rotated_x/y/z and saturated, handed over at an
// edge where out_valid is high and out_stall is low.
// From acceptance to out_valid an item passes three parallel chains of 30 CORDIC cells
// each (one step per cell), one quadrant-mapping stage, three plane-rotation units of
// four stages each, and the clipping output register.
// Throughput is one item per cycle unless the receiver stalls; every stage is a register with no feedback.
// The whole pipeline advances together. When the output register holds an item that the
// receiver stalls, every stage holds and in_stall is raised; otherwise items keep entering.
// Asynchronous reset clears every valid bit, so the pipeline comes up empty and ready.
module euler_point_rotation_xyz_core (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [epr_pkg::COORD_WIDTH-1:0] point_x,
	input  wire logic signed [epr_pkg::COORD_WIDTH-1:0] point_y,
	input  wire logic signed [epr_pkg::COORD_WIDTH-1:0] point_z,
	input  wire logic [epr_pkg::ANGLE_WIDTH-1:0]        angle_about_x,
	input  wire logic [epr_pkg::ANGLE_WIDTH-1:0]        angle_about_y,
	input  wire logic [epr_pkg::ANGLE_WIDTH-1:0]        angle_about_z,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [epr_pkg::COORD_WIDTH-1:0]      rotated_x,
	output logic signed [epr_pkg::COORD_WIDTH-1:0]      rotated_y,
	output logic signed [epr_pkg::COORD_WIDTH-1:0]      rotated_z,
	output logic                                        saturated
);

	localparam int CW = epr_pkg::COORD_WIDTH;
	localparam int AW = epr_pkg::ANGLE_WIDTH;
	localparam int RW = epr_pkg::RW;
	localparam int TW = epr_pkg::TW;
	localparam int NS = epr_pkg::CORDIC_STEPS;
	// Valid stages ahead of the output register: CORDIC, mapping, three rotations.
	localparam int NV = NS + 1 + 12;
	localparam logic signed [RW-1:0] CMAX = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] CMIN = -CMAX - RW'(1);

	logic advance;
	logic v_q [NV];
	logic out_valid_q;

	// The pipeline moves whenever the output register is empty or being taken.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NV; k++) begin
				v_q[k] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_q[0] <= in_valid;
			for (int k = 1; k < NV; k++) begin
				v_q[k] <= v_q[k-1];
			end
			out_valid_q <= v_q[NV-1];
		end
	end

	// CORDIC seed for each axis: the angle is widened to a 32-bit turn fraction, the top
	// two bits choose the quadrant and the low thirty drive the iterations.
	epr_pkg::epr_cordic_t seed [3];
	epr_pkg::epr_cordic_t chain [3][NS+1];
	logic [AW-1:0]        ang [3];
	logic [TW-1:0]        a32 [3];

	assign ang[0] = angle_about_x;
	assign ang[1] = angle_about_y;
	assign ang[2] = angle_about_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			a32[a]       = {ang[a], {(TW - AW){1'b0}}};
			seed[a].x    = epr_pkg::CORDIC_GAIN;
			seed[a].y    = '0;
			seed[a].z    = $signed({2'b00, a32[a][TW-3:0]});
			seed[a].quad = a32[a][TW-1:TW-2];
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		assign chain[a][0] = seed[a];
		for (genvar i = 0; i < NS; i++) begin : g_cell
			epr_cordic_cell u_cell (
				.clk  (clk),
				.en   (advance),
				.step (epr_pkg::STEP_W'(i)),
				.d    (chain[a][i]),
				.q    (chain[a][i+1])
			);
		end
	end

	// The coordinates travel beside the CORDIC chains so that they meet the mapped trig.
	logic signed [CW-1:0] dx_s [NS+1];
	logic signed [CW-1:0] dy_s [NS+1];
	logic signed [CW-1:0] dz_s [NS+1];

	always_ff @(posedge clk) begin
		if (advance) begin
			dx_s[0] <= point_x;
			dy_s[0] <= point_y;
			dz_s[0] <= point_z;
			for (int k = 1; k <= NS; k++) begin
				dx_s[k] <= dx_s[k-1];
				dy_s[k] <= dy_s[k-1];
				dz_s[k] <= dz_s[k-1];
			end
		end
	end

	// Quadrant mapping of the CORDIC cosine and sine.
	logic signed [TW-1:0] cos_s [3];
	logic signed [TW-1:0] sin_s [3];

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int a = 0; a < 3; a++) begin
				case (chain[a][NS].quad)
					2'd0: begin
						cos_s[a] <= chain[a][NS].x;
						sin_s[a] <= chain[a][NS].y;
					end
					2'd1: begin
						cos_s[a] <= -chain[a][NS].y;
						sin_s[a] <= chain[a][NS].x;
					end
					2'd2: begin
						cos_s[a] <= -chain[a][NS].x;
						sin_s[a] <= -chain[a][NS].y;
					end
					default: begin
						cos_s[a] <= chain[a][NS].y;
						sin_s[a] <= -chain[a][NS].x;
					end
				endcase
			end
		end
	end

	// Each rotation has the form p = u*c + v*s, q = v*c - u*s; the axis order is picked by
	// the choice of u, v and the coordinate passed on the side lane.
	epr_pkg::epr_side_t   side_x_i, side_x_o, side_y_i, side_y_o, side_z_i, side_z_o;
	logic signed [RW-1:0] px, qx, py, qy, pz, qz;

	always_comb begin
		side_x_i.w  = RW'(dx_s[NS]);
		side_x_i.c0 = cos_s[1];
		side_x_i.s0 = sin_s[1];
		side_x_i.c1 = cos_s[2];
		side_x_i.s1 = sin_s[2];
	end

	// About x: u = y, v = z, giving y1 and z1.
	epr_rot u_rot_x (
		.clk    (clk),
		.en     (advance),
		.u      (RW'(dy_s[NS])),
		.v      (RW'(dz_s[NS])),
		.c      (cos_s[0]),
		.s      (sin_s[0]),
		.side_i (side_x_i),
		.p      (px),
		.q      (qx),
		.side_o (side_x_o)
	);

	always_comb begin
		side_y_i.w  = px;
		side_y_i.c0 = side_x_o.c1;
		side_y_i.s0 = side_x_o.s1;
		side_y_i.c1 = '0;
		side_y_i.s1 = '0;
	end

	// About y: u = z1, v = x1, giving z2 and x2.
	epr_rot u_rot_y (
		.clk    (clk),
		.en     (advance),
		.u      (qx),
		.v      (side_x_o.w),
		.c      (side_x_o.c0),
		.s      (side_x_o.s0),
		.side_i (side_y_i),
		.p      (py),
		.q      (qy),
		.side_o (side_y_o)
	);

	always_comb begin
		side_z_i    = '0;
		side_z_i.w  = py;
	end

	// About z: u = x2, v = y2, giving x3 and y3; z2 rides the side lane.
	epr_rot u_rot_z (
		.clk    (clk),
		.en     (advance),
		.u      (qy),
		.v      (side_y_o.w),
		.c      (side_y_o.c0),
		.s      (side_y_o.s0),
		.side_i (side_z_i),
		.p      (pz),
		.q      (qz),
		.side_o (side_z_o)
	);

	// Clipping to the coordinate range.
	function automatic logic [CW:0] clip(input logic signed [RW-1:0] val);
		logic [CW:0] r;
		if (val > CMAX) begin
			r = {1'b1, CMAX[CW-1:0]};
		end else if (val < CMIN) begin
			r = {1'b1, CMIN[CW-1:0]};
		end else begin
			r = {1'b0, val[CW-1:0]};
		end
		return r;
	endfunction

	logic [CW:0] cx, cy, cz;

	assign cx = clip(pz);
	assign cy = clip(qz);
	assign cz = clip(side_z_o.w);

	logic signed [CW-1:0] rx_q, ry_q, rz_q;
	logic                 sat_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			rx_q  <= $signed(cx[CW-1:0]);
			ry_q  <= $signed(cy[CW-1:0]);
			rz_q  <= $signed(cz[CW-1:0]);
			sat_q <= cx[CW] | cy[CW] | cz[CW];
		end
	end

	assign out_valid = out_valid_q;
	assign rotated_x = rx_q;
	assign rotated_y = ry_q;
	assign rotated_z = rz_q;
	assign saturated = sat_q;

	// An accepted item always occupies the first stage on the next cycle.
	a_accept_enters : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_q[0])
		else $error("accepted item did not enter the pipeline");

	// When the pipeline advances, the output register takes exactly the last stage's valid.
	a_out_follows : assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |=> out_valid == $past(v_q[NV-1]))
		else $error("output valid does not follow the last stage");

	// A clipped result must sit on one of the range limits.
	a_sat_at_limit : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			(rotated_x == CMAX[CW-1:0]) || (rotated_x == CMIN[CW-1:0]) ||
			(rotated_y == CMAX[CW-1:0]) || (rotated_y == CMIN[CW-1:0]) ||
			(rotated_z == CMAX[CW-1:0]) || (rotated_z == CMIN[CW-1:0]))
		else $error("saturated flag without a clipped coordinate");

endmodule
`default_nettype wire

>>> verif/euler_point_rotation_xyz_core_tb.sv
// Self-checking testbench for the Euler point rotation core, with its own rotation predictor.
`timescale 1ns / 100ps
`default_nettype none
module euler_point_rotation_xyz_core_tb;
	localparam int COORD_WIDTH = epr_pkg::COORD_WIDTH;
	localparam int ANGLE_WIDTH = epr_pkg::ANGLE_WIDTH;

	// Latency given for the block; used for the drain at the end.
	localparam int PIPE_LATENCY = 44;
	localparam int RANDOM_ITEMS = 900;
	localparam int CYCLE_LIMIT  = 200000;
	localparam longint GAIN_Q30 = 652032874;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] px, py, pz;
		logic [ANGLE_WIDTH-1:0]        ax, ay, az;
	} point_item_t;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] rx, ry, rz;
		logic                          sat;
	} rotated_item_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [COORD_WIDTH-1:0] point_x, point_y, point_z;
	logic [ANGLE_WIDTH-1:0]        angle_about_x, angle_about_y, angle_about_z;
	logic signed [COORD_WIDTH-1:0] rotated_x, rotated_y, rotated_z;
	logic                          saturated;

	point_item_t   pending_points[$];
	rotated_item_t expected_rotations[$];
	int  error_count = 0;
	int  cycle_count = 0;
	int  items_sent = 0;
	int  results_seen = 0;
	int  sat_seen = 0;
	bit  stimulus_done = 0;

	euler_point_rotation_xyz_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.angle_about_x(angle_about_x), .angle_about_y(angle_about_y),
		.angle_about_z(angle_about_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z),
		.saturated(saturated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Arithmetic shift right; SystemVerilog's >>> on a signed longint already floors.
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	// Cosine and sine of a turn fraction in Q2.30, by rotation-mode CORDIC plus quadrant fold.
	function automatic void turn_trig(logic [ANGLE_WIDTH-1:0] ang, output longint cs,
			output longint sn);
		longint atan_tab[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5, 3, 1};
		logic [31:0] a32;
		longint x, y, z, dx, dy;
		a32 = {ang, {(32-ANGLE_WIDTH){1'b0}}};
		z = longint'(a32[29:0]);
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		case (a32[31:30])
			2'd0: begin cs = x;  sn = y;  end
			2'd1: begin cs = -y; sn = x;  end
			2'd2: begin cs = -x; sn = -y; end
			default: begin cs = y; sn = -x; end
		endcase
	endfunction

	// Product scaled by 2^-30, rounded to nearest with ties away from zero (128-bit exact).
	function automatic longint scale_q30(longint a, longint c);
		logic signed [127:0] p, m;
		p = 128'(signed'(a)) * 128'(signed'(c));
		m = (p < 0) ? -p : p;
		m = (m + (128'sd1 <<< 29)) >>> 30;
		return longint'((p < 0) ? -m : m);
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] clip_coord(longint v, inout logic sat);
		longint hi, lo;
		hi = (longint'(1) <<< (COORD_WIDTH-1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin v = hi; sat = 1'b1; end
		if (v < lo) begin v = lo; sat = 1'b1; end
		return v[COORD_WIDTH-1:0];
	endfunction

	function automatic rotated_item_t rotate_xyz(point_item_t p);
		rotated_item_t r;
		longint c, s, x1, y1, z1, x2, y2, z2, x3, y3;
		logic sat;
		sat = 1'b0;
		turn_trig(p.ax, c, s);
		x1 = longint'(p.px);
		y1 = scale_q30(longint'(p.py), c) + scale_q30(longint'(p.pz), s);
		z1 = scale_q30(longint'(p.pz), c) - scale_q30(longint'(p.py), s);
		turn_trig(p.ay, c, s);
		x2 = scale_q30(x1, c) - scale_q30(z1, s);
		y2 = y1;
		z2 = scale_q30(x1, s) + scale_q30(z1, c);
		turn_trig(p.az, c, s);
		x3 = scale_q30(x2, c) + scale_q30(y2, s);
		y3 = scale_q30(y2, c) - scale_q30(x2, s);
		r.rx = clip_coord(x3, sat);
		r.ry = clip_coord(y3, sat);
		r.rz = clip_coord(z2, sat);
		r.sat = sat;
		return r;
	endfunction

	// A random coordinate: mostly moderate values, sometimes full-range or extreme ones.
	function automatic logic signed [COORD_WIDTH-1:0] random_coord();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			1, 2, 3: return $urandom;
			default: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
		endcase
	endfunction

	function automatic logic [ANGLE_WIDTH-1:0] random_angle();
		case ($urandom_range(0, 7))
			0: return ANGLE_WIDTH'($urandom_range(0, 3)) << (ANGLE_WIDTH-2);
			1: return ANGLE_WIDTH'((ANGLE_WIDTH'($urandom_range(0, 3)) << (ANGLE_WIDTH-2))
				+ $urandom_range(0, 4) - 2);
			default: return ANGLE_WIDTH'($urandom);
		endcase
	endfunction

	task automatic queue_point(logic signed [COORD_WIDTH-1:0] x, y, z,
			logic [ANGLE_WIDTH-1:0] a, b, g);
		point_item_t p;
		p.px = x; p.py = y; p.pz = z;
		p.ax = a; p.ay = b; p.az = g;
		pending_points.insert(pending_points.size(), p);
	endtask

	// The stimulus: a directed set of corner cases followed by random items.
	initial begin
		// Directed items: identity angles, quarter turns, half turns, the largest angle
		// code, coordinate extremes that clip, and zero and unit points.
		queue_point(0, 0, 0, 0, 0, 0);
		queue_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 0);
		queue_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0);
		queue_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0);
		queue_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 16'h4000, 0, 0);
		queue_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 16'h4000, 0);
		queue_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 16'h4000);
		queue_point(32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 16'h8000, 16'h8000,
			16'h8000);
		queue_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 16'hC000, 16'hC000,
			16'hC000);
		queue_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 16'hFFFF, 16'hFFFF,
			16'hFFFF);
		queue_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 16'h2000, 16'h2000,
			16'h2000);
		queue_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h2000, 16'h1555,
			16'h2000);
		queue_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'h2000, 16'h1555,
			16'h2000);
		queue_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hA000, 16'h6000,
			16'hE000);
		queue_point(32'sh7FFF_FFFF, 0, 0, 0, 0, 16'h2000);
		queue_point(-1, -1, -1, 16'h0001, 16'h0001, 16'h0001);
		queue_point(1, 1, 1, 16'h7FFF, 16'hBFFF, 16'h3FFF);
		queue_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 16'h5555, 16'hAAAA,
			16'h5555);
		queue_point(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 16'hAAAA, 16'h5555,
			16'hAAAA);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			queue_point(random_coord(), random_coord(), random_coord(), random_angle(),
				random_angle(), random_angle());
	end

	// Driver: at each falling edge, offer the next pending item after a random gap.
	// An item is taken at the rising edge where in_valid is high and in_stall is low.
	int send_gap = 0;
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		point_x = '0; point_y = '0; point_z = '0;
		angle_about_x = '0; angle_about_y = '0; angle_about_z = '0;
		clk = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// The stall seen at the last rising edge, so that the driver acts on what the edge saw.
	logic in_stall_at_edge = 1'b0;
	always @(posedge clk)
		in_stall_at_edge <= in_stall;

	always @(negedge clk) begin
		if (arst_n) begin
			// Retire an item the block took at the last rising edge.
			if (in_valid && !in_stall_at_edge) begin
				expected_rotations.insert(expected_rotations.size(),
					rotate_xyz(pending_points.pop_front()));
				items_sent++;
				send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
			end
			if (!in_valid || !in_stall_at_edge) begin
				if (send_gap > 0 || pending_points.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					in_valid <= 1'b0;
				end else begin
					in_valid      <= 1'b1;
					point_x       <= pending_points[0].px;
					point_y       <= pending_points[0].py;
					point_z       <= pending_points[0].pz;
					angle_about_x <= pending_points[0].ax;
					angle_about_y <= pending_points[0].ay;
					angle_about_z <= pending_points[0].az;
				end
			end
			if (pending_points.size() == 0 && !(in_valid && in_stall_at_edge))
				stimulus_done = 1;
		end
	end

	logic out_valid_at_edge = 1'b0;
	always @(posedge clk)
		out_valid_at_edge <= out_valid;

	// Receiver stall: a random stretch of stall cycles drawn for each item, often none.
	int stall_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (out_valid_at_edge && !out_stall)
					stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
			end
		end
	end

	// Monitor: every result handed over is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rotations.size() == 0) begin
				$error("result with no prediction pending: x=%0d y=%0d z=%0d",
					rotated_x, rotated_y, rotated_z);
				error_count++;
			end else begin
				rotated_item_t e;
				e = expected_rotations.pop_front();
				if (rotated_x !== e.rx) begin
					$error("rotated_x: expected %0d, got %0d", e.rx, rotated_x);
					error_count++;
				end
				if (rotated_y !== e.ry) begin
					$error("rotated_y: expected %0d, got %0d", e.ry, rotated_y);
					error_count++;
				end
				if (rotated_z !== e.rz) begin
					$error("rotated_z: expected %0d, got %0d", e.rz, rotated_z);
					error_count++;
				end
				if (saturated !== e.sat) begin
					$error("saturated: expected %0b, got %0b", e.sat, saturated);
					error_count++;
				end
				results_seen++;
				if (saturated === 1'b1)
					sat_seen++;
			end
		end
	end

	// Watchdog: end the run if it is far beyond the slowest correct one.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// End of run: once everything is sent and every prediction met, drain and report.
	initial begin
		wait (stimulus_done && expected_rotations.size() == 0);
		repeat (PIPE_LATENCY + 10) @(posedge clk);
		if (expected_rotations.size() != 0)
			error_count++;
		$display("tb: %0d points sent, %0d rotated and checked, %0d of them clipped",
			items_sent, results_seen, sat_seen);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
